### rtl/core/rnxarb_pkg.sv
// ----------------------------------------------------------------------------
// rnxarb_pkg
// Shared types and constants for the ring neighbor exclusion arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rnxarb_pkg;

  localparam int MAX_AGENTS  = 16;
  localparam int AGENT_W     = 4;
  localparam int NUM_W       = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int OUT_CNT_W   = 16;
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] AGENT_COUNT_RST = CFG_W'(5);

  typedef enum logic [1:0] {
    ST_EATING   = 2'd0,
    ST_HUNGRY   = 2'd1,
    ST_THINKING = 2'd2
  } status_e;

  typedef enum logic {
    OP_TAKE    = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // Status update made when a request is accepted.
  typedef struct packed {
    logic               en;
    logic [AGENT_W-1:0] agent;
    status_e            status;
  } status_wr_t;

  // One pass through the shared grant test.
  typedef struct packed {
    logic               valid;
    logic [AGENT_W-1:0] agent;
    logic               bad;
    logic               last;
  } test_req_t;

endpackage

`default_nettype wire

### rtl/core/rnxarb_grant_unit.sv
// ----------------------------------------------------------------------------
// rnxarb_grant_unit
// Shared grant test: checks one agent against its ring neighbors and forms
// its saturated grant count.
// ----------------------------------------------------------------------------
`default_nettype none

module rnxarb_grant_unit import rnxarb_pkg::*; (
  input  status_e                status_i [MAX_AGENTS],
  input  logic [NUM_W-1:0]       num_i,
  input  logic [AGENT_W-1:0]     agent_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  output logic                   grant_o,
  output logic [COUNT_WIDTH-1:0] count_o
);

  logic [MAX_AGENTS-1:0] eating;
  logic [MAX_AGENTS-1:0] blocked;
  logic [AGENT_W-1:0]    last_agent;

  assign last_agent = AGENT_W'(num_i - NUM_W'(1));

  // Each lane works out whether one of its own ring neighbors is eating.
  for (genvar j = 0; j < MAX_AGENTS; j++) begin : g_lane
    localparam int RIGHT = (j + 1 < MAX_AGENTS) ? j + 1 : 0;
    logic right_eat;
    logic left_eat;

    assign eating[j] = (status_i[j] == ST_EATING);
    assign right_eat = (NUM_W'(j + 1) == num_i) ? eating[0] : eating[RIGHT];
    if (j == 0) begin : g_wrap
      assign left_eat = eating[last_agent];
    end else begin : g_plain
      assign left_eat = eating[j-1];
    end
    assign blocked[j] = right_eat | left_eat;
  end

  assign grant_o = (status_i[agent_i] == ST_HUNGRY) && !blocked[agent_i];

  always_comb begin
    count_o = count_i;
    if (grant_o && (count_i != '1)) begin
      count_o = count_i + COUNT_WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/rnxarb_seq.sv
// ----------------------------------------------------------------------------
// rnxarb_seq
// Sequencer: accepts a request, updates the requester's status and steps the
// shared grant test over the agents to be checked.
// ----------------------------------------------------------------------------
`default_nettype none

module rnxarb_seq import rnxarb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               operation_i,
  input  logic [AGENT_W-1:0] agent_index_i,
  input  logic [NUM_W-1:0]   num_i,
  output logic               busy_o,
  output status_wr_t         wr_o,
  output test_req_t          test_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FIRST  = 3'b010,
    S_SECOND = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic               op_q;
  logic               bad_q;
  logic [AGENT_W-1:0] idx_q;
  logic               accept;
  logic               bad_in;
  logic [AGENT_W-1:0] right_agent;
  logic [AGENT_W-1:0] left_agent;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign bad_in = ({1'b0, agent_index_i} >= num_i);

  assign right_agent = ({1'b0, idx_q} + NUM_W'(1) == num_i) ? '0 : idx_q + AGENT_W'(1);
  assign left_agent  = (idx_q == '0) ? AGENT_W'(num_i - NUM_W'(1)) : idx_q - AGENT_W'(1);

  always_comb begin
    wr_o.en     = accept && !bad_in;
    wr_o.agent  = agent_index_i;
    wr_o.status = (operation_i == OP_RELEASE) ? ST_THINKING : ST_HUNGRY;
  end

  always_comb begin
    state_d      = state_q;
    test_o.valid = 1'b0;
    test_o.agent = idx_q;
    test_o.bad   = bad_q;
    test_o.last  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        test_o.valid = 1'b1;
        if (bad_q || (op_q == OP_TAKE)) begin
          state_d = S_IDLE;
        end else begin
          test_o.agent = right_agent;
          test_o.last  = 1'b0;
          state_d      = S_SECOND;
        end
      end
      S_SECOND: begin
        test_o.valid = 1'b1;
        test_o.agent = left_agent;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      idx_q <= agent_index_i;
      bad_q <= bad_in;
    end
  end

`ifndef ASSERT_OFF
  a_release_two_tests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRST) && !bad_q && (op_q == OP_RELEASE) |=> (state_q == S_SECOND))
    else $error("release did not run its second test");
  a_target_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_o.valid && !test_o.bad |-> ({1'b0, test_o.agent} < num_i))
    else $error("tested agent outside the ring");
  a_no_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == S_IDLE))
    else $error("status write while busy");
`endif

endmodule

`default_nettype wire

### rtl/core/ring_neighbor_exclusion_arbiter_unit.sv
// ----------------------------------------------------------------------------
// ring_neighbor_exclusion_arbiter_unit
// Arbiter for agents in a ring where two neighbors never eat at once.
// ----------------------------------------------------------------------------
// A take request is accepted, then runs one grant test; its result strobes in
// the cycle after the test. A release with an in-range index is accepted, then
// runs two passes of the single shared grant test (right, then left); an
// out-of-range index gets one pass only. busy_o is high while the tests run,
// up to the last one; results cannot be held. Reset (async, active low) sets
// all agents thinking, all counts to zero and the agent count to 5.
`default_nettype none

module ring_neighbor_exclusion_arbiter_unit import rnxarb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 operation_i,
  input  logic [AGENT_W-1:0]   agent_index_i,
  output logic                 result_valid_o,
  output logic [AGENT_W-1:0]   tested_agent_o,
  output logic                 granted_o,
  output logic [OUT_CNT_W-1:0] grant_count_o,
  output logic                 bad_index_o,
  output logic                 last_o
);

  logic [CFG_W-1:0]       agent_count_q;
  logic [NUM_W-1:0]       num_eff;
  status_e                status_q [MAX_AGENTS];
  logic [COUNT_WIDTH-1:0] counter_q [MAX_AGENTS];
  status_wr_t             wr;
  test_req_t              test;
  logic                   unit_grant;
  logic                   grant;
  logic [COUNT_WIDTH-1:0] count_new;

  logic                   valid_q;
  logic [AGENT_W-1:0]     agent_q;
  logic                   granted_q;
  logic [OUT_CNT_W-1:0]   count_q;
  logic                   bad_q;
  logic                   last_q;

  // A count of zero acts as one agent; values above MAX_AGENTS clamp to MAX_AGENTS.
  always_comb begin
    priority if (agent_count_q == '0) begin
      num_eff = NUM_W'(1);
    end else if (agent_count_q > CFG_W'(MAX_AGENTS)) begin
      num_eff = NUM_W'(MAX_AGENTS);
    end else begin
      num_eff = agent_count_q;
    end
  end

  rnxarb_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .operation_i   (operation_i),
    .agent_index_i (agent_index_i),
    .num_i         (num_eff),
    .busy_o        (busy_o),
    .wr_o          (wr),
    .test_o        (test)
  );

  rnxarb_grant_unit u_grant (
    .status_i (status_q),
    .num_i    (num_eff),
    .agent_i  (test.agent),
    .count_i  (counter_q[test.agent]),
    .grant_o  (unit_grant),
    .count_o  (count_new)
  );

  assign grant = test.valid && !test.bad && unit_grant;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agent_count_q <= AGENT_COUNT_RST;
    end else if (cfg_we_i) begin
      agent_count_q <= cfg_wdata_i;
    end
  end

  // Request writes happen only when idle and test writes only when busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        status_q[i]  <= ST_THINKING;
        counter_q[i] <= '0;
      end
    end else begin
      if (wr.en) begin
        status_q[wr.agent] <= wr.status;
      end
      if (grant) begin
        status_q[test.agent]  <= ST_EATING;
        counter_q[test.agent] <= count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= test.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (test.valid) begin
      agent_q   <= test.agent;
      granted_q <= grant;
      count_q   <= test.bad ? '0 : OUT_CNT_W'(count_new);
      bad_q     <= test.bad;
      last_q    <= test.last;
    end
  end

  assign result_valid_o = valid_q;
  assign tested_agent_o = agent_q;
  assign granted_o      = granted_q;
  assign grant_count_o  = count_q;
  assign bad_index_o    = bad_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bad_q |-> last_q && !granted_q && (count_q == '0))
    else $error("bad index result malformed");
  a_grant_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && granted_q |-> (count_q != '0))
    else $error("grant with zero count");
  a_grant_eats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grant |=> (status_q[$past(test.agent)] == ST_EATING))
    else $error("granted agent not eating");
`endif

endmodule

`default_nettype wire

### test/ring_neighbor_exclusion_arbiter_unit_tb.sv
// ----------------------------------------------------------------------------
// ring_neighbor_exclusion_arbiter_unit_tb
// Self-checking bench: directed and random take and release requests are
// checked field by field against a predictor of the ring's eating state.
// ----------------------------------------------------------------------------

module ring_neighbor_exclusion_arbiter_unit_tb;
  import rnxarb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_PRINTS   = 40;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [AGENT_W-1:0]   agent;
    logic                 granted;
    logic [OUT_CNT_W-1:0] count;
    logic                 bad;
    logic                 last;
  } grant_outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic                 operation_i;
  logic [AGENT_W-1:0]   agent_index_i;
  logic                 result_valid_o;
  logic [AGENT_W-1:0]   tested_agent_o;
  logic                 granted_o;
  logic [OUT_CNT_W-1:0] grant_count_o;
  logic                 bad_index_o;
  logic                 last_o;

  // Predicted arbiter state.
  status_e                agent_state [MAX_AGENTS];
  logic [COUNT_WIDTH-1:0] grants      [MAX_AGENTS];
  logic [CFG_W-1:0]       agent_count_reg;

  grant_outcome_t pending_outcomes[$];
  int unsigned    error_count;
  int unsigned    cycles;

  ring_neighbor_exclusion_arbiter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .agent_index_i  (agent_index_i),
    .result_valid_o (result_valid_o),
    .tested_agent_o (tested_agent_o),
    .granted_o      (granted_o),
    .grant_count_o  (grant_count_o),
    .bad_index_o    (bad_index_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycles, what, exp_val, got_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned ring_size();
    if (agent_count_reg < 1) return 1;
    if (agent_count_reg > MAX_AGENTS) return MAX_AGENTS;
    return agent_count_reg;
  endfunction

  function automatic logic try_grant(int unsigned a, int unsigned n);
    int unsigned right;
    int unsigned left;
    right = (a + 1) % n;
    left  = (a + n - 1) % n;
    if (agent_state[right] != ST_EATING && agent_state[left] != ST_EATING &&
        agent_state[a] == ST_HUNGRY) begin
      agent_state[a] = ST_EATING;
      if (grants[a] != '1) grants[a] = grants[a] + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_outcome(int unsigned a, logic g, logic bad, logic last);
    grant_outcome_t o;
    o.agent   = a[AGENT_W-1:0];
    o.granted = g;
    o.count   = bad ? '0 : OUT_CNT_W'(grants[a]);
    o.bad     = bad;
    o.last    = last;
    pending_outcomes.push_back(o);
  endfunction

  function automatic void arbitrate_request(op_e op, logic [AGENT_W-1:0] idx);
    int unsigned n;
    int unsigned a;
    logic        g;
    n = ring_size();
    a = idx;
    if (a >= n) begin
      push_outcome(a, 1'b0, 1'b1, 1'b1);
    end else if (op == OP_TAKE) begin
      agent_state[a] = ST_HUNGRY;
      g = try_grant(a, n);
      push_outcome(a, g, 1'b0, 1'b1);
    end else begin
      // A release retests the right neighbor first, then the left one.
      agent_state[a] = ST_THINKING;
      g = try_grant((a + 1) % n, n);
      push_outcome((a + 1) % n, g, 1'b0, 1'b0);
      g = try_grant((a + n - 1) % n, n);
      push_outcome((a + n - 1) % n, g, 1'b0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    grant_outcome_t exp_o;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result for agent", 0, tested_agent_o);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (tested_agent_o !== exp_o.agent)
          report_mismatch("tested_agent", exp_o.agent, tested_agent_o);
        if (granted_o !== exp_o.granted)
          report_mismatch("granted", exp_o.granted, granted_o);
        if (grant_count_o !== exp_o.count)
          report_mismatch("grant_count", exp_o.count, grant_count_o);
        if (bad_index_o !== exp_o.bad)
          report_mismatch("bad_index", exp_o.bad, bad_index_o);
        if (last_o !== exp_o.last)
          report_mismatch("last", exp_o.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // start_i stays high after acceptance so back-to-back requests need no gap.
  task automatic send_request(op_e op, logic [AGENT_W-1:0] idx);
    @(negedge clk_i);
    start_i       <= 1'b1;
    operation_i   <= op;
    agent_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    arbitrate_request(op, idx);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_agent_count(logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    agent_count_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_default_ring();
    send_request(OP_TAKE, 4'd0);
    send_request(OP_TAKE, 4'd1);
    send_request(OP_TAKE, 4'd2);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_RELEASE, 4'd2);
    // An agent that is already eating asks again and is granted once more.
    send_request(OP_TAKE, 4'd1);
    send_request(OP_TAKE, 4'd5);
    send_request(OP_RELEASE, 4'd15);
  endtask

  task automatic test_single_agent();
    // A count of zero behaves like a ring of one.
    write_agent_count(5'd0);
    send_request(OP_TAKE, 4'd0);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_TAKE, 4'd0);
    send_request(OP_TAKE, 4'd1);
    write_agent_count(5'd1);
    send_request(OP_TAKE, 4'd0);
    send_request(OP_RELEASE, 4'd0);
  endtask

  task automatic test_wide_rings();
    write_agent_count(5'd31);
    send_request(OP_TAKE, 4'd15);
    send_request(OP_TAKE, 4'd14);
    send_request(OP_RELEASE, 4'd15);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_TAKE, 4'd8);
    write_agent_count(5'd16);
    send_request(OP_TAKE, 4'd15);
    send_request(OP_RELEASE, 4'd15);
    write_agent_count(5'd17);
    send_request(OP_TAKE, 4'd7);
  endtask

  task automatic test_count_change();
    write_agent_count(5'd3);
    send_request(OP_TAKE, 4'd2);
    send_request(OP_TAKE, 4'd4);
    write_agent_count(5'd16);
    send_request(OP_TAKE, 4'd4);
    send_request(OP_RELEASE, 4'd3);
  endtask

  task automatic test_repeated_take();
    // In a ring of one every take grants, so the counter climbs each time.
    write_agent_count(5'd1);
    repeat (20) send_request(OP_TAKE, 4'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned phases, int unsigned per_phase);
    int unsigned      burst_left;
    int unsigned      n;
    logic [CFG_W-1:0] count_val;
    logic [AGENT_W-1:0] idx;
    op_e              op;
    burst_left = $urandom_range(1, 12);
    for (int unsigned p = 0; p < phases; p++) begin
      case (p)
        0:       count_val = 5'd16;
        1:       count_val = 5'd2;
        2:       count_val = 5'd31;
        3:       count_val = 5'd3;
        default: count_val = CFG_W'($urandom_range(1, 31));
      endcase
      write_agent_count(count_val);
      n = ring_size();
      for (int unsigned i = 0; i < per_phase; i++) begin
        idx = ($urandom_range(0, 99) < 88) ? AGENT_W'($urandom_range(0, n - 1))
                                           : AGENT_W'($urandom_range(0, 15));
        op  = op_e'($urandom_range(0, 1));
        send_request(op, idx);
        // One phase runs flat out; the others come in bursts.
        if (p != 4) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
          end
        end
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    start_i       <= 1'b0;
    operation_i   <= 1'b0;
    agent_index_i <= '0;
    cycles        <= 0;
    error_count   = 0;
    agent_count_reg = AGENT_COUNT_RST;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      agent_state[i] = ST_THINKING;
      grants[i]      = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_ring();
    test_single_agent();
    test_wide_rings();
    test_count_change();
    test_repeated_take();
    test_random_traffic(8, 45);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
